>>> hw/rtl/att_pkg.sv
// shared types and codes of the allocation tracking table
package att_pkg;

	localparam int BLOCK_ENTRIES_DEF = 256;
	localparam int GROUP_ENTRIES_DEF = 64;

	localparam int ADDR_W = 64;
	localparam int SIZE_W = 32;
	localparam int CNT_W  = 32;

	localparam logic [2:0] REQ_BEGIN   = 3'd0;
	localparam logic [2:0] REQ_END     = 3'd1;
	localparam logic [2:0] REQ_MALLOC  = 3'd2;
	localparam logic [2:0] REQ_FREE    = 3'd3;
	localparam logic [2:0] REQ_REALLOC = 3'd4;
	localparam logic [2:0] REQ_QUERY   = 3'd5;

	localparam logic [2:0] ST_DONE       = 3'd0;
	localparam logic [2:0] ST_DISABLED   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_BLOCK_FULL = 3'd3;
	localparam logic [2:0] ST_GROUP_FULL = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_B,
		S_DRAIN_B,
		S_CHECK_B,
		S_SCAN_G,
		S_DRAIN_G,
		S_CHECK_G,
		S_WRITE_R,
		S_WRITE_A,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		K_MALLOC,
		K_FREE,
		K_MOVE,
		K_QUERY,
		K_NONE
	} kind_t;

endpackage

>>> hw/rtl/allocation_tracking_table_core.sv
// allocation tracking table: live block table and size group statistics
// One event is taken at a time and answered with one result beat. For malloc,
// free and realloc the block memory and then the group memory are scanned one
// entry per cycle to find the address, the size group and the lowest free
// slots, then the entries are written back. A query scans only the group
// memory; begin, end and events ignored while tracking is off go straight to
// the result. No clearing pass after reset is needed. A finished result waits
// in an output register while the next event is accepted.
module allocation_tracking_table_core #(
	parameter int BLOCK_ENTRIES = att_pkg::BLOCK_ENTRIES_DEF,
	parameter int GROUP_ENTRIES = att_pkg::GROUP_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [2:0]                 req_type,
	input  logic [att_pkg::ADDR_W-1:0] addr,
	input  logic [att_pkg::ADDR_W-1:0] new_addr,
	input  logic [att_pkg::SIZE_W-1:0] size,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [2:0]                 status,
	output logic [att_pkg::CNT_W-1:0]  live_blocks,
	output logic [att_pkg::CNT_W-1:0]  live_bytes,
	output logic                       group_found,
	output logic [att_pkg::CNT_W-1:0]  group_alive,
	output logic [att_pkg::CNT_W-1:0]  group_peak,
	output logic [att_pkg::CNT_W-1:0]  group_total
);

	localparam int BW  = $clog2(BLOCK_ENTRIES);
	localparam int GW  = $clog2(GROUP_ENTRIES);
	localparam int AW  = att_pkg::ADDR_W;
	localparam int SW  = att_pkg::SIZE_W;
	localparam int CW  = att_pkg::CNT_W;
	localparam int BDW = AW + SW;
	localparam int GDW = SW + 3 * CW;

	att_pkg::state_t state_q, state_d;
	att_pkg::kind_t  kind_q;

	logic                     tracking_q;
	logic [BLOCK_ENTRIES-1:0] bvalid_q;
	logic [GROUP_ENTRIES-1:0] gvalid_q;
	logic [CW-1:0]            blk_cnt_q, byte_cnt_q;

	logic [BDW-1:0] bmem [BLOCK_ENTRIES];
	logic [GDW-1:0] gmem [GROUP_ENTRIES];
	logic [BDW-1:0] brd_s1;
	logic [GDW-1:0] grd_s1;

	logic [BW-1:0] bidx_q, bidx_s1;
	logic [GW-1:0] gidx_q, gidx_s1;
	logic          bchk_s1, bvld_s1, gchk_s1, gvld_s1;

	logic [AW-1:0] a_q, n_q;
	logic [SW-1:0] s_q, osz_q;
	logic [2:0]    st_q;

	logic          hit_a_q, hit_n_q, fr_b_q;
	logic [BW-1:0] ia_q, in_q, fb_q;
	logic          hit_s_q, hit_o_q, fr_g_q;
	logic [GW-1:0] is_q, io_q, fg_q;
	logic [3*CW-1:0] cnt_s_q, cnt_o_q;

	logic          rsp_valid_q;
	logic [2:0]    rsp_status_q;
	logic [CW-1:0] rsp_blocks_q, rsp_bytes_q, rsp_alive_q, rsp_peak_q, rsp_total_q;
	logic          rsp_found_q;

	logic          accept, b_last, g_last, b_rd, g_rd;
	logic          b_fail, g_fail, combine, rem_we, add_we, gwe, bwe;
	logic [BW-1:0] mv_tgt, bwa;
	logic [BDW-1:0] bwd;
	logic [GW-1:0] gwa, gia;
	logic [GDW-1:0] gwd;
	logic [CW-1:0] base_alive, base_peak, base_total, new_alive, new_peak;

	assign b_last = bidx_q == BW'(BLOCK_ENTRIES - 1);
	assign g_last = gidx_q == GW'(GROUP_ENTRIES - 1);
	assign b_fail = (kind_q == att_pkg::K_MALLOC) ? (!hit_a_q && !fr_b_q) : !hit_a_q;
	assign g_fail = (kind_q == att_pkg::K_MALLOC || kind_q == att_pkg::K_MOVE) &&
		!hit_s_q && !fr_g_q;
	assign mv_tgt = (hit_n_q && in_q != ia_q) ? in_q : ia_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			att_pkg::S_IDLE: begin
				if (req_valid) begin
					case (req_type)
						att_pkg::REQ_QUERY: state_d = att_pkg::S_SCAN_G;
						att_pkg::REQ_MALLOC, att_pkg::REQ_FREE, att_pkg::REQ_REALLOC:
							state_d = tracking_q ? att_pkg::S_SCAN_B : att_pkg::S_RESP;
						default: state_d = att_pkg::S_RESP;
					endcase
				end
			end
			att_pkg::S_SCAN_B: if (b_last) state_d = att_pkg::S_DRAIN_B;
			att_pkg::S_DRAIN_B: state_d = att_pkg::S_CHECK_B;
			att_pkg::S_CHECK_B: state_d = b_fail ? att_pkg::S_RESP : att_pkg::S_SCAN_G;
			att_pkg::S_SCAN_G: if (g_last) state_d = att_pkg::S_DRAIN_G;
			att_pkg::S_DRAIN_G: state_d = att_pkg::S_CHECK_G;
			att_pkg::S_CHECK_G: begin
				if (kind_q == att_pkg::K_QUERY || g_fail) state_d = att_pkg::S_RESP;
				else state_d = att_pkg::S_WRITE_R;
			end
			att_pkg::S_WRITE_R: begin
				state_d = (kind_q == att_pkg::K_FREE) ? att_pkg::S_RESP : att_pkg::S_WRITE_A;
			end
			att_pkg::S_WRITE_A: state_d = att_pkg::S_RESP;
			att_pkg::S_RESP: if (!rsp_valid_q || !rsp_stall) state_d = att_pkg::S_IDLE;
			default: state_d = att_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_stall = state_q != att_pkg::S_IDLE;
		b_rd      = state_q == att_pkg::S_SCAN_B;
		g_rd      = state_q == att_pkg::S_SCAN_G;
		bwe       = state_q == att_pkg::S_WRITE_R &&
			(kind_q == att_pkg::K_MALLOC || kind_q == att_pkg::K_MOVE);
		rem_we    = state_q == att_pkg::S_WRITE_R &&
			(kind_q == att_pkg::K_FREE || kind_q == att_pkg::K_MOVE) && hit_o_q && !combine;
		add_we    = state_q == att_pkg::S_WRITE_A;
	end

	assign accept  = req_valid && !req_stall;
	assign combine = kind_q == att_pkg::K_MOVE && hit_o_q && hit_s_q && is_q == io_q;

	// block write
	always_comb begin
		if (kind_q == att_pkg::K_MALLOC) begin
			bwa = hit_a_q ? ia_q : fb_q;
			bwd = {a_q, s_q};
		end else begin
			bwa = mv_tgt;
			bwd = {n_q, s_q};
		end
	end

	// group write, remove then add
	always_comb begin
		gia        = hit_s_q ? is_q : fg_q;
		base_alive = hit_s_q ? cnt_s_q[3*CW-1:2*CW] : '0;
		base_peak  = hit_s_q ? cnt_s_q[2*CW-1:CW] : '0;
		base_total = hit_s_q ? cnt_s_q[CW-1:0] : '0;
		if (combine) base_alive = base_alive - CW'(1);
		new_alive = base_alive + CW'(1);
		new_peak  = (new_alive > base_peak) ? new_alive : base_peak;
		gwe = rem_we || add_we;
		if (add_we) begin
			gwa = gia;
			gwd = {s_q, new_alive, new_peak, base_total + CW'(1)};
		end else begin
			gwa = io_q;
			gwd = {osz_q, cnt_o_q[3*CW-1:2*CW] - CW'(1), cnt_o_q[2*CW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (bwe) bmem[bwa] <= bwd;
		if (b_rd) brd_s1 <= bmem[bidx_q];
	end

	always_ff @(posedge clk) begin
		if (gwe) gmem[gwa] <= gwd;
		if (g_rd) grd_s1 <= gmem[gidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= att_pkg::S_IDLE;
			tracking_q  <= 1'b0;
			bvalid_q    <= '0;
			gvalid_q    <= '0;
			blk_cnt_q   <= '0;
			byte_cnt_q  <= '0;
			bidx_q      <= '0;
			gidx_q      <= '0;
			bchk_s1     <= 1'b0;
			gchk_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bchk_s1 <= b_rd;
			gchk_s1 <= g_rd;
			bidx_q  <= b_rd ? bidx_q + BW'(1) : '0;
			gidx_q  <= g_rd ? gidx_q + GW'(1) : '0;
			if (accept && req_type == att_pkg::REQ_BEGIN) begin
				tracking_q <= 1'b1;
				bvalid_q   <= '0;
				blk_cnt_q  <= '0;
				byte_cnt_q <= '0;
			end
			if (accept && req_type == att_pkg::REQ_END) begin
				tracking_q <= 1'b0;
				bvalid_q   <= '0;
				gvalid_q   <= '0;
				blk_cnt_q  <= '0;
				byte_cnt_q <= '0;
			end
			if (state_q == att_pkg::S_WRITE_R) begin
				case (kind_q)
					att_pkg::K_MALLOC: begin
						bvalid_q[bwa] <= 1'b1;
						blk_cnt_q     <= blk_cnt_q + CW'(1);
						byte_cnt_q    <= byte_cnt_q + s_q;
					end
					att_pkg::K_FREE: begin
						bvalid_q[ia_q] <= 1'b0;
						blk_cnt_q      <= blk_cnt_q - CW'(1);
						byte_cnt_q     <= byte_cnt_q - osz_q;
					end
					att_pkg::K_MOVE: begin
						if (mv_tgt != ia_q) bvalid_q[ia_q] <= 1'b0;
						byte_cnt_q <= byte_cnt_q - osz_q + s_q;
					end
					default: ;
				endcase
			end
			if (add_we) gvalid_q[gia] <= 1'b1;
			if (state_q == att_pkg::S_RESP && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// event registers and scan results
	always_ff @(posedge clk) begin
		bidx_s1 <= bidx_q;
		bvld_s1 <= bvalid_q[bidx_q];
		gidx_s1 <= gidx_q;
		gvld_s1 <= gvalid_q[gidx_q];
		if (accept) begin
			n_q     <= new_addr;
			s_q     <= size;
			a_q     <= (req_type == att_pkg::REQ_REALLOC && addr == '0) ? new_addr : addr;
			hit_a_q <= 1'b0;
			hit_n_q <= 1'b0;
			fr_b_q  <= 1'b0;
			hit_s_q <= 1'b0;
			hit_o_q <= 1'b0;
			fr_g_q  <= 1'b0;
			if (!tracking_q && (req_type == att_pkg::REQ_MALLOC ||
				req_type == att_pkg::REQ_FREE || req_type == att_pkg::REQ_REALLOC)) begin
				st_q   <= att_pkg::ST_DISABLED;
				kind_q <= att_pkg::K_NONE;
			end else begin
				st_q <= att_pkg::ST_DONE;
				case (req_type)
					att_pkg::REQ_MALLOC: kind_q <= att_pkg::K_MALLOC;
					att_pkg::REQ_FREE:   kind_q <= att_pkg::K_FREE;
					att_pkg::REQ_REALLOC: begin
						if (addr == '0) kind_q <= att_pkg::K_MALLOC;
						else if (size == '0) kind_q <= att_pkg::K_FREE;
						else kind_q <= att_pkg::K_MOVE;
					end
					att_pkg::REQ_QUERY: kind_q <= att_pkg::K_QUERY;
					default: kind_q <= att_pkg::K_NONE;
				endcase
			end
		end
		if (bchk_s1) begin
			if (bvld_s1) begin
				if (!hit_a_q && brd_s1[BDW-1:SW] == a_q) begin
					hit_a_q <= 1'b1;
					ia_q    <= bidx_s1;
					osz_q   <= brd_s1[SW-1:0];
				end
				if (!hit_n_q && brd_s1[BDW-1:SW] == n_q) begin
					hit_n_q <= 1'b1;
					in_q    <= bidx_s1;
				end
			end else if (!fr_b_q) begin
				fr_b_q <= 1'b1;
				fb_q   <= bidx_s1;
			end
		end
		if (gchk_s1) begin
			if (gvld_s1) begin
				if (!hit_s_q && grd_s1[GDW-1:3*CW] == s_q) begin
					hit_s_q <= 1'b1;
					is_q    <= gidx_s1;
					cnt_s_q <= grd_s1[3*CW-1:0];
				end
				if (!hit_o_q && grd_s1[GDW-1:3*CW] == osz_q) begin
					hit_o_q <= 1'b1;
					io_q    <= gidx_s1;
					cnt_o_q <= grd_s1[3*CW-1:0];
				end
			end else if (!fr_g_q) begin
				fr_g_q <= 1'b1;
				fg_q   <= gidx_s1;
			end
		end
		if (state_q == att_pkg::S_CHECK_B && b_fail) begin
			st_q <= (kind_q == att_pkg::K_MALLOC) ? att_pkg::ST_BLOCK_FULL
				: att_pkg::ST_NOT_FOUND;
		end
		if (state_q == att_pkg::S_CHECK_G && kind_q != att_pkg::K_QUERY && g_fail) begin
			st_q <= att_pkg::ST_GROUP_FULL;
		end
		if (state_q == att_pkg::S_RESP && (!rsp_valid_q || !rsp_stall)) begin
			rsp_status_q <= st_q;
			rsp_blocks_q <= blk_cnt_q;
			rsp_bytes_q  <= byte_cnt_q;
			if (kind_q == att_pkg::K_QUERY && hit_s_q) begin
				rsp_found_q <= 1'b1;
				rsp_alive_q <= cnt_s_q[3*CW-1:2*CW];
				rsp_peak_q  <= cnt_s_q[2*CW-1:CW];
				rsp_total_q <= cnt_s_q[CW-1:0];
			end else begin
				rsp_found_q <= 1'b0;
				rsp_alive_q <= '0;
				rsp_peak_q  <= '0;
				rsp_total_q <= '0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign live_blocks = rsp_blocks_q;
	assign live_bytes  = rsp_bytes_q;
	assign group_found = rsp_found_q;
	assign group_alive = rsp_alive_q;
	assign group_peak  = rsp_peak_q;
	assign group_total = rsp_total_q;

endmodule

>>> hw/rtl/att_chk.sv
// port checker of the allocation tracking table and its bind
module att_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input logic [2:0]                status,
	input logic [att_pkg::CNT_W-1:0] live_blocks,
	input logic                      group_found,
	input logic [att_pkg::CNT_W-1:0] group_alive,
	input logic [att_pkg::CNT_W-1:0] group_peak,
	input logic [att_pkg::CNT_W-1:0] group_total
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(live_blocks))
		else $error("stalled result beat changed");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second event taken before result");

	a_no_group_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !group_found |-> group_alive == '0 && group_peak == '0 &&
		group_total == '0)
		else $error("group counts without a group");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && group_found |-> status == att_pkg::ST_DONE)
		else $error("group found with error status");

endmodule

bind allocation_tracking_table_core att_chk u_att_chk (.*);
